@@ rtl/core/rdf_pkg.sv @@
// Shared constants for the radius distance filter.
// Holds the configuration register index codes; depends on nothing.
package rdf_pkg;

  // Configuration register index.
  localparam int CFG_IDX_WIDTH = 2;
  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_REF_X  = 2'd0;
  localparam cfg_idx_t CFG_REF_Y  = 2'd1;
  localparam cfg_idx_t CFG_REF_Z  = 2'd2;
  localparam cfg_idx_t CFG_CUTOFF = 2'd3;

endpackage

@@ rtl/core/rdf_if.sv @@
// Valid/ready stream interfaces for the radius distance filter.
// One interface for point words and one for result words; no dependencies.
interface rdf_point_if #(
  parameter int COORD_WIDTH = 24,
  parameter int TAG_WIDTH   = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic        [TAG_WIDTH-1:0]   point_tag;
  logic                          point_last;

  modport source (output valid, point_x, point_y, point_z, point_tag, point_last,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_tag, point_last,
                  output ready);
endinterface

interface rdf_result_if #(
  parameter int DIST_WIDTH = 25,
  parameter int TAG_WIDTH  = 32
);
  logic                  valid;
  logic                  ready;
  logic [DIST_WIDTH-1:0] distance;
  logic [TAG_WIDTH-1:0]  result_tag;
  logic                  within_res;
  logic                  result_last;

  modport source (output valid, distance, result_tag, within_res, result_last,
                  input ready);
  modport sink   (input valid, distance, result_tag, within_res, result_last,
                  output ready);
endinterface

@@ rtl/core/radius_distance_filter_core.sv @@
// Radius distance filter: floor Euclidean distance of each point to a reference point.
// Pipeline: difference, square and sum stages, then one pipelined square-root stage per result bit.
// Throughput is one word per cycle while the output is not stalled.
// Each stage holds its word when the next is full, so output stalls lose nothing.
// Synchronous active-low reset clears all stage valid bits and the configuration registers.
// Depends on rdf_pkg and the interfaces in rdf_if.sv.
module radius_distance_filter_core #(
  parameter int COORD_WIDTH = 24,
  parameter int TAG_WIDTH   = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  rdf_pkg::cfg_idx_t            cfg_index,
  input  logic [COORD_WIDTH:0]         cfg_data,
  rdf_point_if.sink                    in_pt,
  rdf_result_if.source                 out_res
);
  import rdf_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;  // difference magnitude and distance width
  localparam int SW  = 2 * DW;           // squared and summed value width
  localparam int NSQ = DW;               // one root bit per stage

  // Configuration registers and the squared cutoff derived from the cutoff register.
  logic [COORD_WIDTH-1:0] ref_x_r, ref_y_r, ref_z_r;
  logic [DW-1:0]          cutoff_r;
  logic [SW-1:0]          cut_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r  <= '0;
      ref_y_r  <= '0;
      ref_z_r  <= '0;
      cutoff_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_X:  ref_x_r  <= cfg_data[COORD_WIDTH-1:0];
        CFG_REF_Y:  ref_y_r  <= cfg_data[COORD_WIDTH-1:0];
        CFG_REF_Z:  ref_z_r  <= cfg_data[COORD_WIDTH-1:0];
        CFG_CUTOFF: cutoff_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The user must change the cutoff only while idle; the core itself does not enforce it.
  always_ff @(posedge clk) begin
    cut_sq_r <= cutoff_r * cutoff_r;
  end

  // Magnitude of the difference of two signed coordinates.
  function automatic logic [DW-1:0] abs_diff(input logic [COORD_WIDTH-1:0] a,
                                             input logic [COORD_WIDTH-1:0] b);
    logic [DW-1:0] d;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    return d[DW-1] ? (~d + DW'(1)) : d;
  endfunction

  // Stage ready chain: a stage loads when it is empty or its successor moves.
  logic           s1_rdy, s2_rdy, s3_rdy;
  logic [NSQ-1:0] sq_rdy;

  // Stage 1: coordinate differences.
  logic                 s1_vld_r;
  logic [DW-1:0]        s1_dx_r, s1_dy_r, s1_dz_r;
  logic [TAG_WIDTH-1:0] s1_tag_r;
  logic                 s1_last_r;

  assign s1_rdy      = !s1_vld_r || s2_rdy;
  assign in_pt.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_pt.valid) begin
      s1_dx_r   <= abs_diff(in_pt.point_x, ref_x_r);
      s1_dy_r   <= abs_diff(in_pt.point_y, ref_y_r);
      s1_dz_r   <= abs_diff(in_pt.point_z, ref_z_r);
      s1_tag_r  <= in_pt.point_tag;
      s1_last_r <= in_pt.point_last;
    end
  end

  // Stage 2: squares.
  logic                 s2_vld_r;
  logic [SW-1:0]        s2_sx_r, s2_sy_r, s2_sz_r;
  logic [TAG_WIDTH-1:0] s2_tag_r;
  logic                 s2_last_r;

  assign s2_rdy = !s2_vld_r || s3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      s2_sx_r   <= s1_dx_r * s1_dx_r;
      s2_sy_r   <= s1_dy_r * s1_dy_r;
      s2_sz_r   <= s1_dz_r * s1_dz_r;
      s2_tag_r  <= s1_tag_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: sum of squares. Three squares of at most 2^COORD_WIDTH fit in SW bits.
  logic                 s3_vld_r;
  logic [SW-1:0]        s3_sum_r;
  logic [TAG_WIDTH-1:0] s3_tag_r;
  logic                 s3_last_r;

  assign s3_rdy = !s3_vld_r || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_vld_r) begin
      s3_sum_r  <= s2_sx_r + s2_sy_r + s2_sz_r;
      s3_tag_r  <= s2_tag_r;
      s3_last_r <= s2_last_r;
    end
  end

  // Square-root stages: one digit-by-digit step each, highest bit first.
  logic [NSQ-1:0]       sq_vld_r;
  logic [SW-1:0]        sq_rem_r    [NSQ];
  logic [SW-1:0]        sq_root_r   [NSQ];
  logic [TAG_WIDTH-1:0] sq_tag_r    [NSQ];
  logic [NSQ-1:0]       sq_within_r;
  logic [NSQ-1:0]       sq_last_r;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [SW-1:0] RBIT = SW'(1) << (SW - 2 - 2 * k);

    logic                 vld_in, within_in, last_in, rdy_dn, take;
    logic [SW-1:0]        rem_in, root_in, trial;
    logic [TAG_WIDTH-1:0] tag_in;

    // The first step also does the exact radius test on the squared sum.
    if (k == 0) begin : g_first
      assign vld_in    = s3_vld_r;
      assign rem_in    = s3_sum_r;
      assign root_in   = '0;
      assign tag_in    = s3_tag_r;
      assign last_in   = s3_last_r;
      assign within_in = (s3_sum_r <= cut_sq_r);
    end else begin : g_next
      assign vld_in    = sq_vld_r[k-1];
      assign rem_in    = sq_rem_r[k-1];
      assign root_in   = sq_root_r[k-1];
      assign tag_in    = sq_tag_r[k-1];
      assign last_in   = sq_last_r[k-1];
      assign within_in = sq_within_r[k-1];
    end

    if (k == NSQ - 1) begin : g_tail
      assign rdy_dn = out_res.ready;
    end else begin : g_mid
      assign rdy_dn = sq_rdy[k+1];
    end

    assign sq_rdy[k] = !sq_vld_r[k] || rdy_dn;
    assign trial     = root_in + RBIT;
    assign take      = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (sq_rdy[k]) begin
        sq_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (sq_rdy[k] && vld_in) begin
        sq_rem_r[k]    <= take ? (rem_in - trial) : rem_in;
        sq_root_r[k]   <= take ? ((root_in >> 1) + RBIT) : (root_in >> 1);
        sq_tag_r[k]    <= tag_in;
        sq_last_r[k]   <= last_in;
        sq_within_r[k] <= within_in;
      end
    end
  end

  // Result word comes straight from the last root stage.
  assign out_res.valid       = sq_vld_r[NSQ-1];
  assign out_res.distance    = sq_root_r[NSQ-1][DW-1:0];
  assign out_res.result_tag  = sq_tag_r[NSQ-1];
  assign out_res.within_res  = sq_within_r[NSQ-1];
  assign out_res.result_last = sq_last_r[NSQ-1];

  // An accepted point always lands in the first stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pt.valid && in_pt.ready) |=> s1_vld_r)
    else $error("accepted point did not enter the pipeline");

  // The root always fits the distance width.
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld_r[NSQ-1] |-> (sq_root_r[NSQ-1][SW-1:DW] == '0))
    else $error("square root overflowed the distance width");

  // A kept point never has a floor distance above the cutoff.
  a_keep_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.within_res) |-> (out_res.distance <= cutoff_r))
    else $error("kept point has distance above cutoff");

  // A rejected point has a floor distance of at least the cutoff.
  a_drop_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.within_res) |-> (out_res.distance >= cutoff_r))
    else $error("rejected point has distance below cutoff");

endmodule

@@ tb/radius_distance_filter_core_tb.sv @@
// Self-checking testbench for radius_distance_filter_core: a directed table, then random
// point words checked against a distance predictor, with random idling and a long stall.
// Depends on rdf_pkg, the stream interfaces in rdf_if.sv and the core itself.
module radius_distance_filter_core_tb;
  import rdf_pkg::*;

  localparam int CW = 24;
  localparam int DW = CW + 1;
  localparam int TW = 32;
  localparam int LATENCY = CW + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 110;
  localparam int HOLD_CYCLES = 300;

  localparam logic [CW-1:0] CMIN = 24'h800000;
  localparam logic [CW-1:0] CMAX = 24'h7FFFFF;
  localparam longint COORD_LO = -(longint'(1) << (CW - 1));
  localparam longint COORD_HI = (longint'(1) << (CW - 1)) - 1;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [TW-1:0] tag;
    logic          last;
  } point_t;

  typedef struct packed {
    logic [DW-1:0] distance;
    logic [TW-1:0] tag;
    logic          keep;
    logic          last;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

  // A setup row carries the reference point in x, y, z and the cutoff in cut.
  typedef struct packed {
    row_kind_t     kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [DW-1:0] cut;
    logic [TW-1:0] tag;
    logic          last;
    logic          typed;
    logic [DW-1:0] distance;
    logic          keep;
  } row_t;

  localparam int DIR_ROWS_N = 20;
  localparam row_t DIR_ROWS [DIR_ROWS_N] = '{
    // Reset setup: reference at the origin, zero cutoff.
    '{ROW_POINT, 24'h0, 24'h0, 24'h0, 25'h0, 32'h00000000, 1'b0, 1'b1, 25'd0, 1'b1},
    '{ROW_POINT, 24'h1, 24'h0, 24'h0, 25'h0, 32'hFFFFFFFF, 1'b1, 1'b1, 25'd1, 1'b0},
    '{ROW_POINT, 24'h3, 24'h4, 24'h0, 25'h0, 32'hA5A5A5A5, 1'b0, 1'b1, 25'd5, 1'b0},
    '{ROW_POINT, 24'h0, 24'h0, 24'hFFFFFF, 25'h0, 32'h5A5A5A5A, 1'b1, 1'b1, 25'd1, 1'b0},
    // Distance exactly at the cutoff, and just above it with the same floor.
    '{ROW_CFG, 24'h0, 24'h0, 24'h0, 25'd5, 32'h0, 1'b0, 1'b0, 25'd0, 1'b0},
    '{ROW_POINT, 24'h3, 24'h4, 24'h0, 25'h0, 32'h00000001, 1'b0, 1'b1, 25'd5, 1'b1},
    '{ROW_POINT, 24'h0, 24'hFFFFFD, 24'h4, 25'h0, 32'h80000000, 1'b1, 1'b1, 25'd5, 1'b1},
    '{ROW_POINT, 24'h0, 24'h4, 24'hFFFFFC, 25'h0, 32'h7FFFFFFF, 1'b0, 1'b1, 25'd5, 1'b0},
    '{ROW_POINT, 24'h6, 24'h0, 24'h0, 25'h0, 32'h12345678, 1'b1, 1'b1, 25'd6, 1'b0},
    // Reference at the top corner, widest cutoff.
    '{ROW_CFG, CMAX, CMAX, CMAX, 25'h1FFFFFF, 32'h0, 1'b0, 1'b0, 25'd0, 1'b0},
    '{ROW_POINT, CMIN, CMIN, CMIN, 25'h0, 32'hDEADBEEF, 1'b1, 1'b0, 25'd0, 1'b0},
    '{ROW_POINT, CMAX, CMAX, CMAX, 25'h0, 32'h0000FFFF, 1'b0, 1'b1, 25'd0, 1'b1},
    '{ROW_POINT, CMIN, CMAX, 24'h0, 25'h0, 32'hFFFF0000, 1'b1, 1'b0, 25'd0, 1'b0},
    // Reference at the bottom corner, zero cutoff.
    '{ROW_CFG, CMIN, CMIN, CMIN, 25'h0, 32'h0, 1'b0, 1'b0, 25'd0, 1'b0},
    '{ROW_POINT, CMAX, CMAX, CMAX, 25'h0, 32'hCAFEF00D, 1'b0, 1'b0, 25'd0, 1'b0},
    '{ROW_POINT, CMIN, CMIN, CMIN, 25'h0, 32'h00000000, 1'b1, 1'b1, 25'd0, 1'b1},
    '{ROW_POINT, 24'h0, 24'h0, 24'h0, 25'h0, 32'hFFFFFFFF, 1'b0, 1'b0, 25'd0, 1'b0},
    // Cutoff of exactly 0x1000 (4096 in integer distance units) around an off-origin reference.
    '{ROW_CFG, 24'h123456, 24'h123456, 24'h123456, 25'h1000, 32'h0, 1'b0, 1'b0, 25'd0, 1'b0},
    '{ROW_POINT, 24'h124456, 24'h123456, 24'h123456, 25'h0, 32'h0BADF00D, 1'b1, 1'b1,
      25'h1000, 1'b1},
    '{ROW_POINT, 24'h124457, 24'h123456, 24'h123456, 25'h0, 32'h600DCAFE, 1'b0, 1'b1,
      25'h1001, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CW:0] cfg_data;

  rdf_point_if #(.COORD_WIDTH(CW), .TAG_WIDTH(TW)) pt_if ();
  rdf_result_if #(.DIST_WIDTH(DW), .TAG_WIDTH(TW)) res_if ();

  radius_distance_filter_core #(
    .COORD_WIDTH(CW),
    .TAG_WIDTH  (TW)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_pt    (pt_if),
    .out_res  (res_if)
  );

  always #4 clk = ~clk;

  // Mirror of the configuration registers, updated once a whole setup has been written.
  logic [CW-1:0] ref_x_cfg;
  logic [CW-1:0] ref_y_cfg;
  logic [CW-1:0] ref_z_cfg;
  logic [DW-1:0] cutoff_cfg;

  result_t results_pending[$];
  int errors = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit no_idle = 1'b0;

  // Exact floor square root, one result bit at a time from the top.
  function automatic logic [DW-1:0] floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = DW; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    return r[DW-1:0];
  endfunction

  // Distance, keep flag and passthrough fields of one point under the current setup.
  function automatic result_t point_distance(input point_t p);
    longint dx;
    longint dy;
    longint dz;
    longint unsigned sum;
    longint unsigned cut;
    result_t r;
    dx = longint'($signed(p.x)) - longint'($signed(ref_x_cfg));
    dy = longint'($signed(p.y)) - longint'($signed(ref_y_cfg));
    dz = longint'($signed(p.z)) - longint'($signed(ref_z_cfg));
    sum = dx * dx + dy * dy + dz * dz;
    cut = 64'(cutoff_cfg);
    r.distance = floor_root(sum);
    r.tag      = p.tag;
    r.keep     = (sum <= cut * cut);
    r.last     = p.last;
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input longint v);
    if (v > COORD_HI) begin
      v = COORD_HI;
    end
    if (v < COORD_LO) begin
      v = COORD_LO;
    end
    return v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] extreme_coord();
    case ($urandom_range(0, 2))
      0: return CMIN;
      1: return CMAX;
      default: return '0;
    endcase
  endfunction

  // Random point: often near the reference so the keep flag goes both ways, as often
  // full-range noise, and now and then corner values or points right on the cutoff.
  function automatic point_t random_point();
    point_t p;
    longint span;
    longint cut;
    longint rx;
    longint ry;
    longint rz;
    int unsigned range_hi;
    int mode;
    mode = $urandom_range(0, 9);
    cut = longint'(cutoff_cfg);
    rx = longint'($signed(ref_x_cfg));
    ry = longint'($signed(ref_y_cfg));
    rz = longint'($signed(ref_z_cfg));
    span = cut;
    if (span > (longint'(1) << 22)) begin
      span = longint'(1) << 22;
    end
    if (span < 1) begin
      span = 1;
    end
    range_hi = 32'(2 * span);
    if (mode <= 3) begin
      p.x = clamp_coord(rx + longint'($urandom_range(0, range_hi)) - span);
      p.y = clamp_coord(ry + longint'($urandom_range(0, range_hi)) - span);
      p.z = clamp_coord(rz + longint'($urandom_range(0, range_hi)) - span);
    end else if (mode <= 7) begin
      p.x = CW'($urandom);
      p.y = CW'($urandom);
      p.z = CW'($urandom);
    end else if (mode == 8) begin
      p.x = extreme_coord();
      p.y = extreme_coord();
      p.z = extreme_coord();
    end else begin
      if (rx + cut <= COORD_HI) begin
        p.x = clamp_coord(rx + cut);
      end else if (rx - cut >= COORD_LO) begin
        p.x = clamp_coord(rx - cut);
      end else begin
        p.x = ref_x_cfg;
      end
      p.y = ref_y_cfg;
      p.z = ref_z_cfg;
    end
    p.tag  = TW'($urandom);
    p.last = 1'($urandom_range(0, 1));
    return p;
  endfunction

  // Offer one point word, idling at random first, and queue its expected result
  // once the core takes it. Returns at the falling edge after the handshake.
  task automatic push_point(input point_t p, input result_t want);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      pt_if.valid <= 1'b0;
      @(negedge clk);
    end
    pt_if.valid      <= 1'b1;
    pt_if.point_x    <= p.x;
    pt_if.point_y    <= p.y;
    pt_if.point_z    <= p.z;
    pt_if.point_tag  <= p.tag;
    pt_if.point_last <= p.last;
    @(posedge clk);
    while (!pt_if.ready) begin
      @(posedge clk);
    end
    results_pending.insert(results_pending.size(), want);
    @(negedge clk);
  endtask

  // Stop offering words and wait until every expected result has come back.
  task automatic wait_drained();
    pt_if.valid <= 1'b0;
    while (results_pending.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CW:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Write all four registers; the reference writes carry a random unused top bit.
  task automatic program_regs(input logic [CW-1:0] rx, input logic [CW-1:0] ry,
                              input logic [CW-1:0] rz, input logic [DW-1:0] cut);
    logic spare;
    spare = 1'($urandom_range(0, 1));
    write_reg(CFG_REF_X, {spare, rx});
    write_reg(CFG_REF_Y, {~spare, ry});
    write_reg(CFG_REF_Z, {spare, rz});
    write_reg(CFG_CUTOFF, cut);
    cfg_we <= 1'b0;
    ref_x_cfg  = rx;
    ref_y_cfg  = ry;
    ref_z_cfg  = rz;
    cutoff_cfg = cut;
  endtask

  task automatic note_mismatch(input string field, input longint unsigned want,
                               input longint unsigned got);
    errors++;
    if (errors <= 10) begin
      $display("MISMATCH %s: expected %0h, got %0h", field, want, got);
    end
  endtask

  // Result word checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      results_seen++;
      if (results_pending.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("MISMATCH unexpected result word, distance %0h", res_if.distance);
        end
      end else begin
        want = results_pending.pop_front();
        if (res_if.distance !== want.distance) begin
          note_mismatch("distance", want.distance, res_if.distance);
        end
        if (res_if.result_tag !== want.tag) begin
          note_mismatch("result_tag", want.tag, res_if.result_tag);
        end
        if (res_if.within_res !== want.keep) begin
          note_mismatch("within_res", want.keep, res_if.within_res);
        end
        if (res_if.result_last !== want.last) begin
          note_mismatch("result_last", want.last, res_if.result_last);
        end
      end
    end
  end

  // Result side: random stalls, one long hold-off to back up the pipeline.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= 500) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, then random phases under fresh setups.
  initial begin
    row_t row;
    point_t pt;
    result_t want;
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    logic [CW-1:0] rz;
    logic [DW-1:0] cut;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_REF_X;
    cfg_data         = '0;
    pt_if.valid      = 1'b0;
    pt_if.point_x    = '0;
    pt_if.point_y    = '0;
    pt_if.point_z    = '0;
    pt_if.point_tag  = '0;
    pt_if.point_last = 1'b0;
    ref_x_cfg        = '0;
    ref_y_cfg        = '0;
    ref_z_cfg        = '0;
    cutoff_cfg       = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        program_regs(row.x, row.y, row.z, row.cut);
      end else begin
        pt = '{row.x, row.y, row.z, row.tag, row.last};
        if (row.typed) begin
          want = '{row.distance, row.tag, row.keep, row.last};
        end else begin
          want = point_distance(pt);
        end
        push_point(pt, want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 0) begin
        rx = CMIN;
        ry = CMAX;
        rz = '0;
        cut = '1;
      end else if (ph == 1) begin
        rx = CMAX;
        ry = CMIN;
        rz = CMAX;
        cut = '0;
      end else begin
        rx = ($urandom_range(0, 7) == 0) ? extreme_coord() : CW'($urandom);
        ry = CW'($urandom);
        rz = CW'($urandom);
        case ($urandom_range(0, 2))
          0: cut = DW'($urandom_range(0, 1 << 16));
          1: cut = DW'($urandom_range(0, 1 << 22));
          default: cut = DW'($urandom);
        endcase
      end
      program_regs(rx, ry, rz, cut);
      // One phase runs without random idling or random stalls on either side.
      no_idle = (ph == 4);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pt = random_point();
        push_point(pt, point_distance(pt));
      end
      no_idle = 1'b0;
    end

    wait_drained();
    repeat (LATENCY + 12) @(negedge clk);
    errors += results_pending.size();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rdf_pkg.sv
rtl/core/rdf_if.sv
rtl/core/radius_distance_filter_core.sv
tb/radius_distance_filter_core_tb.sv
